FILE: rtl/kc2d_pkg.sv
// ----------------------------------------------------------------------------
// kc2d_pkg: shared types and constants of the 2-D convolution block
// Field widths, register codes, reset values and the structs passed between
// the configuration, line buffer, multiply-accumulate and output stages.
// ----------------------------------------------------------------------------
package kc2d_pkg;

	localparam int PIX_W          = 8;
	localparam int COORD_W        = 11;
	localparam int KROW_W         = 60;
	localparam int NUM_KROWS      = 5;
	localparam int KSIZE_W        = 3;
	localparam int DIM_W          = 12;
	localparam int REG_IDX_W      = 3;
	localparam int MAX_HEIGHT     = 2048;
	localparam int OUT_TDATA_W    = 32;

	localparam int DEF_MAX_WIDTH      = 2048;
	localparam int DEF_MAX_KERNEL     = 5;
	localparam int DEF_COEF_WIDTH     = 12;
	localparam int DEF_COEF_FRAC_BITS = 10;

	localparam logic [KROW_W-1:0]  KROW0_RST  = 60'd1074266176;
	localparam logic [KROW_W-1:0]  KROW1_RST  = 60'd2148532352;
	localparam logic [KROW_W-1:0]  KROW2_RST  = 60'd1074266176;
	localparam logic [KROW_W-1:0]  KROW3_RST  = 60'd0;
	localparam logic [KROW_W-1:0]  KROW4_RST  = 60'd0;
	localparam logic [KSIZE_W-1:0] KSIZE_RST  = 3'd3;
	localparam logic [DIM_W-1:0]   WIDTH_RST  = 12'd640;
	localparam logic [DIM_W-1:0]   HEIGHT_RST = 12'd480;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_KERNEL_ROW_0 = 3'd0,
		REG_KERNEL_ROW_1 = 3'd1,
		REG_KERNEL_ROW_2 = 3'd2,
		REG_KERNEL_ROW_3 = 3'd3,
		REG_KERNEL_ROW_4 = 3'd4,
		REG_KERNEL_SIZE  = 3'd5,
		REG_FRAME_WIDTH  = 3'd6,
		REG_FRAME_HEIGHT = 3'd7
	} kc2d_reg_t;

	// Effective configuration as seen by the datapath.
	typedef struct packed {
		logic [NUM_KROWS-1:0][KROW_W-1:0] kernel;
		logic [KSIZE_W-1:0]               k;
		logic [DIM_W-1:0]                 width;
		logic [DIM_W-1:0]                 height;
	} kc2d_cfg_t;

	// Per-pixel bookkeeping that travels alongside the window.
	typedef struct packed {
		logic               emit;
		logic               done;
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
	} kc2d_meta_t;

	typedef struct packed {
		logic               done;
		logic [COORD_W-1:0] cy;
		logic [COORD_W-1:0] cx;
		logic [PIX_W-1:0]   value;
	} kc2d_result_t;

endpackage

FILE: rtl/kernel_convolution_2d_top.sv
// ----------------------------------------------------------------------------
// kernel_convolution_2d_top: streaming 2-D convolution of gray pixels
// Raster pixels in, one filtered pixel out for every full kernel window.
// ----------------------------------------------------------------------------
// The block takes one 8-bit pixel per clock in raster order and, once the
// window covers K full rows and K full columns, returns the kernel sum for
// the window centre, shifted by the fraction bits and clamped to 0..255.
// Sustained rate is one pixel per clock while the output buffer has room;
// this is set by the line memory, which does one read and one write-back of
// a column word per pixel, with a one-entry forward when two pixels in a row
// hit the same column. A result leaves the output buffer once the output
// side is ready. Border pixels never produce a result, and a frame smaller
// than the kernel produces none at all. After reset every column word of the
// line memory is cleared, during which s_axis_tready stays
// low; configuration writes are taken at any time but are meant to be made
// while no request is in flight. The tuser bit marks the first pixel of a
// frame and restarts the column and row counters; tlast on the output marks
// the result whose newest pixel is the last pixel of the frame.
// ----------------------------------------------------------------------------
module kernel_convolution_2d_top #(
	parameter int MAX_WIDTH      = kc2d_pkg::DEF_MAX_WIDTH,
	parameter int MAX_KERNEL     = kc2d_pkg::DEF_MAX_KERNEL,
	parameter int COEF_WIDTH     = kc2d_pkg::DEF_COEF_WIDTH,
	parameter int COEF_FRAC_BITS = kc2d_pkg::DEF_COEF_FRAC_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Pixel requests in.
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [kc2d_pkg::PIX_W-1:0]           s_axis_tdata,  // [7:0] pixel_value
	input  logic [0:0]                           s_axis_tuser,  // [0] start_of_frame
	// Filtered pixel requests out.
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [7:0] filtered_value, [18:8] centre_x, [29:19] centre_y, [31:30] zero
	output logic [kc2d_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	output logic                                 m_axis_tlast,  // frame_done
	// Configuration writes.
	input  logic                                 cfg_we,
	input  logic [kc2d_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [kc2d_pkg::KROW_W-1:0]          cfg_data
);

	kc2d_pkg::kc2d_cfg_t    cfg;
	kc2d_pkg::kc2d_meta_t   meta_s2;
	kc2d_pkg::kc2d_result_t res;
	kc2d_pkg::kc2d_result_t out_res;
	logic [MAX_KERNEL*MAX_KERNEL-1:0][kc2d_pkg::PIX_W-1:0] window;

	logic en;
	logic take;
	logic clearing;
	logic v_s2;
	logic res_valid;
	logic fifo_full;

	// The whole pipeline moves together; it holds only when a finished result
	// has nowhere to go because both output buffer entries are occupied.
	assign en            = !(res_valid && fifo_full);
	assign s_axis_tready = en && !clearing;
	assign take          = s_axis_tvalid && s_axis_tready;

	kc2d_cfg #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_KERNEL (MAX_KERNEL)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Counters, line memory and the KxK window.
	kc2d_line_window #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_KERNEL (MAX_KERNEL)
	) u_line_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.cfg      (cfg),
		.take     (take),
		.pix      (s_axis_tdata),
		.sof      (s_axis_tuser[0]),
		.clearing (clearing),
		.v_s2     (v_s2),
		.meta_s2  (meta_s2),
		.window_q (window)
	);

	// Products, row sums, total and clamp.
	kc2d_mac #(
		.MAX_KERNEL     (MAX_KERNEL),
		.COEF_WIDTH     (COEF_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg),
		.v_in      (v_s2),
		.meta_in   (meta_s2),
		.window    (window),
		.res_valid (res_valid),
		.res       (res)
	);

	kc2d_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (en && res_valid),
		.push_data (res),
		.full      (fifo_full),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_res)
	);

	assign m_axis_tdata = {2'b00, out_res.cy, out_res.cx, out_res.value};
	assign m_axis_tlast = out_res.done;

endmodule

FILE: rtl/kc2d_cfg.sv
// ----------------------------------------------------------------------------
// kc2d_cfg: configuration registers
// Holds the written registers and derives the kernel size and frame size
// that the datapath actually uses.
// ----------------------------------------------------------------------------
module kc2d_cfg #(
	parameter int MAX_WIDTH  = kc2d_pkg::DEF_MAX_WIDTH,
	parameter int MAX_KERNEL = kc2d_pkg::DEF_MAX_KERNEL
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [kc2d_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [kc2d_pkg::KROW_W-1:0]      cfg_data,
	output kc2d_pkg::kc2d_cfg_t              cfg
);

	localparam int KW = kc2d_pkg::KSIZE_W;
	localparam int DW = kc2d_pkg::DIM_W;

	logic [kc2d_pkg::NUM_KROWS-1:0][kc2d_pkg::KROW_W-1:0] kernel_q;
	logic [KW-1:0] ksize_q;
	logic [DW-1:0] width_q;
	logic [DW-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q[0] <= kc2d_pkg::KROW0_RST;
			kernel_q[1] <= kc2d_pkg::KROW1_RST;
			kernel_q[2] <= kc2d_pkg::KROW2_RST;
			kernel_q[3] <= kc2d_pkg::KROW3_RST;
			kernel_q[4] <= kc2d_pkg::KROW4_RST;
			ksize_q     <= kc2d_pkg::KSIZE_RST;
			width_q     <= kc2d_pkg::WIDTH_RST;
			height_q    <= kc2d_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index) inside
				kc2d_pkg::REG_KERNEL_ROW_0, kc2d_pkg::REG_KERNEL_ROW_1,
				kc2d_pkg::REG_KERNEL_ROW_2, kc2d_pkg::REG_KERNEL_ROW_3,
				kc2d_pkg::REG_KERNEL_ROW_4: begin
					kernel_q[cfg_index] <= cfg_data;
				end
				kc2d_pkg::REG_KERNEL_SIZE: begin
					ksize_q <= cfg_data[KW-1:0];
				end
				kc2d_pkg::REG_FRAME_WIDTH: begin
					width_q <= cfg_data[DW-1:0];
				end
				kc2d_pkg::REG_FRAME_HEIGHT: begin
					height_q <= cfg_data[DW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Zero becomes one, even sizes round down, and the result is capped.
	function automatic logic [KW-1:0] eff_kernel(input logic [KW-1:0] r);
		logic [KW-1:0] v;
		v = (r == '0) ? KW'(1) : r;
		if (!v[0]) v = v - KW'(1);
		if (v > KW'(MAX_KERNEL)) v = KW'(MAX_KERNEL);
		if (!v[0]) v = v - KW'(1);
		return v;
	endfunction

	function automatic logic [DW-1:0] eff_dim(input logic [DW-1:0] r, input int maxv);
		logic [DW-1:0] v;
		if (r == '0) v = DW'(1);
		else if ({2'b00, r} > 14'(maxv)) v = DW'(maxv);
		else v = r;
		return v;
	endfunction

	always_comb begin
		cfg.kernel = kernel_q;
		cfg.k      = eff_kernel(ksize_q);
		cfg.width  = eff_dim(width_q, MAX_WIDTH);
		cfg.height = eff_dim(height_q, kc2d_pkg::MAX_HEIGHT);
	end

endmodule

FILE: rtl/kc2d_line_window.sv
// ----------------------------------------------------------------------------
// kc2d_line_window: raster counters, line memory and sliding window
// One memory word per column holds that column's pixels from the stored
// lines. Each pixel reads its word, replaces one slot and writes it back;
// a one-entry forward covers back-to-back pixels in the same column.
// ----------------------------------------------------------------------------
module kc2d_line_window #(
	parameter int MAX_WIDTH  = kc2d_pkg::DEF_MAX_WIDTH,
	parameter int MAX_KERNEL = kc2d_pkg::DEF_MAX_KERNEL
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  kc2d_pkg::kc2d_cfg_t                   cfg,
	input  logic                                  take,
	input  logic [kc2d_pkg::PIX_W-1:0]            pix,
	input  logic                                  sof,
	output logic                                  clearing,
	output logic                                  v_s2,
	output kc2d_pkg::kc2d_meta_t                  meta_s2,
	output logic [MAX_KERNEL*MAX_KERNEL-1:0][kc2d_pkg::PIX_W-1:0] window_q
);

	localparam int PW     = kc2d_pkg::PIX_W;
	localparam int MK     = MAX_KERNEL;
	localparam int LINES  = MAX_KERNEL - 1;
	localparam int LIDX_W = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int CW     = kc2d_pkg::COORD_W;
	localparam int KW     = kc2d_pkg::KSIZE_W;

	typedef logic [LINES-1:0][PW-1:0] word_t;

	word_t line_mem [MAX_WIDTH];

	logic [COL_W-1:0]             col_q;
	logic [CW-1:0]                row_q;
	logic [LINES-1:0][LIDX_W-1:0] rmod_q;
	logic [COL_W-1:0]             clr_q;
	logic                         clearing_q;

	logic [COL_W-1:0]             c0;
	logic [CW-1:0]                r0;
	logic [LINES-1:0][LIDX_W-1:0] rm0;
	logic [LIDX_W-1:0]            rmod_sel;
	logic [KW-1:0]                n;
	logic [KW-1:0]                nm1;
	logic [KW-1:0]                half;
	logic                         last_col;
	logic                         last_row;
	logic [13:0]                  cx_full;
	kc2d_pkg::kc2d_meta_t         meta0;

	logic                         v_s1;
	logic [COL_W-1:0]             c_s1;
	logic [PW-1:0]                pix_s1;
	logic [LIDX_W-1:0]            rmod_s1;
	kc2d_pkg::kc2d_meta_t         meta_s1;
	word_t                        mem_rd_s1;
	word_t                        fwd_word_s1;
	logic                         fwd_sel_s1;

	word_t                        word;
	word_t                        new_word;
	logic                         wr_en;
	logic [MK-1:0][PW-1:0]        col_vals;
	logic [MK*MK-1:0][PW-1:0]     window_d;

	assign clearing = clearing_q;

	// Stage 0: position of the accepted pixel.
	always_comb begin
		c0   = sof ? '0 : col_q;
		r0   = sof ? '0 : row_q;
		rm0  = sof ? '0 : rmod_q;
		n    = cfg.k - KW'(1);
		nm1  = n - KW'(1);
		half = cfg.k >> 1;
		rmod_sel = (n == '0) ? '0 : rm0[nm1[LIDX_W-1:0]];
		last_col = (14'(c0) + 14'd1) >= 14'(cfg.width);
		last_row = (12'(r0) + 12'd1) >= cfg.height;
		cx_full  = 14'(c0) - 14'(half);
		meta0.emit = ((14'(c0) + 14'd1) >= 14'(cfg.k)) && ((12'(r0) + 12'd1) >= 12'(cfg.k));
		meta0.done = last_col && last_row;
		meta0.cx   = cx_full[CW-1:0];
		meta0.cy   = r0 - CW'(half);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			rmod_q     <= '0;
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else begin
			if (clearing_q) begin
				clr_q <= clr_q + COL_W'(1);
				if (clr_q == COL_W'(MAX_WIDTH - 1)) clearing_q <= 1'b0;
			end
			if (take) begin
				if (last_col) begin
					col_q <= '0;
					if (last_row) begin
						row_q  <= '0;
						rmod_q <= '0;
					end else begin
						row_q <= r0 + CW'(1);
						for (int m = 0; m < LINES; m++) begin
							rmod_q[m] <= (rm0[m] == LIDX_W'(m)) ? '0 : rm0[m] + LIDX_W'(1);
						end
					end
				end else begin
					col_q  <= c0 + COL_W'(1);
					row_q  <= r0;
					rmod_q <= rm0;
				end
			end
		end
	end

	// Stage 1: the column word arrives; pick the window column and patch the word.
	always_comb begin
		int s;
		word  = fwd_sel_s1 ? fwd_word_s1 : mem_rd_s1;
		wr_en = (n != '0);
		new_word = word;
		new_word[rmod_s1] = pix_s1;
		for (int i = 0; i < MK; i++) begin
			s = int'(rmod_s1) + i;
			if (s >= int'(n)) s = s - int'(n);
			if (i < int'(n)) col_vals[i] = word[LIDX_W'(s)];
			else col_vals[i] = pix_s1;
		end
	end

	always_comb begin
		int src;
		for (int i = 0; i < MK; i++) begin
			for (int j = 0; j < MK; j++) begin
				src = (j < MK - 1) ? i * MK + j + 1 : i * MK + j;
				window_d[i*MK+j] = window_q[i*MK+j];
				if (i < int'(cfg.k)) begin
					if (j + 1 < int'(cfg.k)) window_d[i*MK+j] = window_q[src];
					else if (j + 1 == int'(cfg.k)) window_d[i*MK+j] = col_vals[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			line_mem[clr_q] <= '0;
		end else if (en && v_s1 && wr_en) begin
			line_mem[c_s1] <= new_word;
		end
		if (en) begin
			mem_rd_s1 <= line_mem[c0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			fwd_sel_s1 <= 1'b0;
			v_s2       <= 1'b0;
			window_q   <= '0;
		end else if (en) begin
			v_s1       <= take;
			fwd_sel_s1 <= take && v_s1 && wr_en && (c0 == c_s1);
			v_s2       <= v_s1;
			if (v_s1) window_q <= window_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1        <= c0;
			pix_s1      <= pix;
			rmod_s1     <= rmod_sel;
			meta_s1     <= meta0;
			fwd_word_s1 <= new_word;
			meta_s2     <= meta_s1;
		end
	end

endmodule

FILE: rtl/kc2d_mac.sv
// ----------------------------------------------------------------------------
// kc2d_mac: window times kernel
// Registered products, then per-row sums, then the total; the output value
// is the total shifted by the fraction bits and clamped to 0..255.
// ----------------------------------------------------------------------------
module kc2d_mac #(
	parameter int MAX_KERNEL     = kc2d_pkg::DEF_MAX_KERNEL,
	parameter int COEF_WIDTH     = kc2d_pkg::DEF_COEF_WIDTH,
	parameter int COEF_FRAC_BITS = kc2d_pkg::DEF_COEF_FRAC_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  kc2d_pkg::kc2d_cfg_t                   cfg,
	input  logic                                  v_in,
	input  kc2d_pkg::kc2d_meta_t                  meta_in,
	input  logic [MAX_KERNEL*MAX_KERNEL-1:0][kc2d_pkg::PIX_W-1:0] window,
	output logic                                  res_valid,
	output kc2d_pkg::kc2d_result_t                res
);

	localparam int PW     = kc2d_pkg::PIX_W;
	localparam int MK     = MAX_KERNEL;
	localparam int PROD_W = COEF_WIDTH + PW + 1;
	localparam int RSUM_W = PROD_W + $clog2(MK);
	localparam int SUM_W  = RSUM_W + $clog2(MK);
	localparam int KRW    = kc2d_pkg::KROW_W;

	logic signed [PROD_W-1:0] prod_d [MK*MK];
	logic signed [PROD_W-1:0] prod_s3 [MK*MK];
	logic signed [RSUM_W-1:0] rsum_d [MK];
	logic signed [RSUM_W-1:0] rsum_s4 [MK];
	logic signed [SUM_W-1:0]  sum_d;
	logic signed [SUM_W-1:0]  sum_s5;
	logic [SUM_W-1:0]         shifted;
	logic                     v_s3, v_s4, v_s5;
	kc2d_pkg::kc2d_meta_t     meta_s3, meta_s4, meta_s5;

	// Coefficient j of a row; bits past the register read as zero.
	function automatic logic [COEF_WIDTH-1:0] coef_bits(input logic [KRW-1:0] row,
		input int j);
		logic [KRW-1:0] t;
		t = row >> (COEF_WIDTH * j);
		return t[COEF_WIDTH-1:0];
	endfunction

	always_comb begin
		logic signed [COEF_WIDTH-1:0] cf;
		logic signed [PW:0]           px;
		for (int i = 0; i < MK; i++) begin
			for (int j = 0; j < MK; j++) begin
				cf = '0;
				if (i < kc2d_pkg::NUM_KROWS && i < int'(cfg.k) && j < int'(cfg.k))
					cf = coef_bits(cfg.kernel[i], j);
				px = {1'b0, window[i*MK+j]};
				prod_d[i*MK+j] = cf * px;
			end
		end
	end

	always_comb begin
		logic signed [RSUM_W-1:0] acc;
		for (int i = 0; i < MK; i++) begin
			acc = '0;
			for (int j = 0; j < MK; j++) acc = acc + RSUM_W'(prod_s3[i*MK+j]);
			rsum_d[i] = acc;
		end
	end

	always_comb begin
		sum_d = '0;
		for (int i = 0; i < MK; i++) sum_d = sum_d + SUM_W'(rsum_s4[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_in && meta_in.emit;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= prod_d;
			rsum_s4 <= rsum_d;
			sum_s5  <= sum_d;
			meta_s3 <= meta_in;
			meta_s4 <= meta_s3;
			meta_s5 <= meta_s4;
		end
	end

	always_comb begin
		shifted   = SUM_W'(sum_s5) >> COEF_FRAC_BITS;
		res_valid = v_s5;
		res.done  = meta_s5.done;
		res.cx    = meta_s5.cx;
		res.cy    = meta_s5.cy;
		if (sum_s5[SUM_W-1]) res.value = '0;
		else if (|shifted[SUM_W-1:PW]) res.value = '1;
		else res.value = shifted[PW-1:0];
	end

endmodule

FILE: rtl/kc2d_out_fifo.sv
// ----------------------------------------------------------------------------
// kc2d_out_fifo: two-entry result buffer
// Separates the pipeline from the output handshake so the input side keeps
// moving while a result waits.
// ----------------------------------------------------------------------------
module kc2d_out_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  kc2d_pkg::kc2d_result_t push_data,
	output logic                   full,
	output logic                   out_valid,
	input  logic                   out_ready,
	output kc2d_pkg::kc2d_result_t out_data
);

	kc2d_pkg::kc2d_result_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign full      = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = entry_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

endmodule

FILE: rtl/kc2d_checker.sv
// ----------------------------------------------------------------------------
// kc2d_checker: port-level checks of the convolution block
// Output handshake rules, the clearing pass after reset and input back
// pressure, bound to the top level.
// ----------------------------------------------------------------------------
module kc2d_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [kc2d_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                             m_axis_tlast
);

	// A stalled result stays offered.
	a_out_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output request dropped while stalled");

	// A stalled result keeps its payload.
	a_out_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output payload changed while stalled");

	// The line memory clearing pass keeps the input closed right after reset.
	a_clear_after_reset: assert property (@(posedge clk)
		!arst_n |=> !s_axis_tready)
		else $error("input opened before the line memory was cleared");

	// Input back pressure only comes from a full output buffer.
	a_ready_drop_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$past(s_axis_tready) && !s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no result waiting");

endmodule

bind kernel_convolution_2d_top kc2d_checker u_kc2d_checker (.*);

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the streaming 2-D convolution block
// Streams raster pixels through kernel_convolution_2d_top under random
// idling and back-pressure, predicts every filtered pixel in the bench, and
// compares each output request field by field against the predicted one.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import kc2d_pkg::*;

	// Geometry of the block as instantiated with its default parameters.
	localparam int MAX_W     = DEF_MAX_WIDTH;
	localparam int MAX_K     = DEF_MAX_KERNEL;
	localparam int CW        = DEF_COEF_WIDTH;
	localparam int FRAC      = DEF_COEF_FRAC_BITS;
	localparam int LINES     = MAX_K - 1;

	// Run-length guards. The settle time outlasts the pipeline, so the block
	// is quiet before registers are touched.
	localparam int SETTLE_CYCLES = 24;
	localparam int DRAIN_LIMIT   = 50000;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int HOLD_CYCLES   = 400;
	localparam int PRINT_LIMIT   = 60;

	typedef enum int {
		IDLE_SENDER_LIGHT,
		IDLE_RECEIVER_LIGHT,
		IDLE_NONE
	} idle_mode_t;

	typedef enum int {
		KERNEL_SMOOTH,
		KERNEL_SIGNED,
		KERNEL_WILD,
		KERNEL_ZERO,
		KERNEL_ALL_ONES,
		KERNEL_MAX_POS,
		KERNEL_MAX_NEG
	} kernel_kind_t;

	// One predicted filtered pixel, as it should appear on the output bus.
	typedef struct packed {
		logic [PIX_W-1:0]   value;
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic               done;
	} filtered_pixel_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [PIX_W-1:0]       s_axis_tdata = '0;
	logic [0:0]             s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	logic                   cfg_we = 1'b0;
	logic [REG_IDX_W-1:0]   cfg_index = '0;
	logic [KROW_W-1:0]      cfg_data = '0;

	kernel_convolution_2d_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// ------------------------------------------------------------------
	// Bench state: idling knobs, the store of predicted pixels, counters.
	// ------------------------------------------------------------------
	int              send_idle_pct = 0;
	int              recv_idle_pct = 0;
	logic            rx_hold = 1'b0;
	int              mismatch_count = 0;
	int              cycle_count = 0;
	filtered_pixel_t expected_pixels[$];

	// Shadow of the block's registers and of its pixel memories. The line
	// memory is kept per line slot and the window as rows of columns, with
	// column 0 holding the oldest pixel.
	logic [KROW_W-1:0]  kernel_rows[NUM_KROWS];
	logic [KSIZE_W-1:0] ksize_reg;
	logic [DIM_W-1:0]   width_reg;
	logic [DIM_W-1:0]   height_reg;
	logic [PIX_W-1:0]   line_mem[LINES][MAX_W];
	logic [PIX_W-1:0]   window[MAX_K][MAX_K];
	int                 col_count;
	int                 row_count;

	initial begin
		forever #5 clk = ~clk;
	end

	// A hung handshake must not hang the run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Prediction.
	// ------------------------------------------------------------------
	task automatic reset_predictor();
		kernel_rows[0] = KROW0_RST;
		kernel_rows[1] = KROW1_RST;
		kernel_rows[2] = KROW2_RST;
		kernel_rows[3] = KROW3_RST;
		kernel_rows[4] = KROW4_RST;
		ksize_reg = KSIZE_RST;
		width_reg = WIDTH_RST;
		height_reg = HEIGHT_RST;
		foreach (line_mem[i, j]) line_mem[i][j] = '0;
		foreach (window[i, j]) window[i][j] = '0;
		col_count = 0;
		row_count = 0;
	endtask

	// The kernel side actually used: zero reads as one, even sizes round
	// down, and anything past the largest supported side clamps to it.
	function automatic int kernel_side();
		int k;
		k = ksize_reg;
		if (k == 0) k = 1;
		if (k % 2 == 0) k = k - 1;
		if (k > MAX_K) k = MAX_K;
		if (k % 2 == 0) k = k - 1;
		return k;
	endfunction

	function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	// Advances the shadow by one accepted pixel. Returns 1 when the window
	// is full, with the pixel the block must produce in res.
	function automatic bit convolve_pixel(input logic [PIX_W-1:0] pix, input logic sof,
			output filtered_pixel_t res);
		int k, w, h, c, r, n, slot, half;
		logic [PIX_W-1:0] column[MAX_K];
		logic signed [CW-1:0] cf;
		longint acc;
		bit last_col, last_row, full;
		k = kernel_side();
		w = clamp_dim(width_reg, MAX_W);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		res = '0;
		if (sof) begin
			col_count = 0;
			row_count = 0;
		end
		c = col_count % MAX_W;
		r = row_count;

		// New window column: the k-1 rows above from the line memory, then
		// the incoming pixel at the bottom.
		if (k > 1) begin
			n = k - 1;
			for (int i = 0; i < n; i++) begin
				slot = (r % n + i) % n;
				column[i] = line_mem[slot][c];
			end
			line_mem[r % n][c] = pix;
		end
		column[k-1] = pix;

		for (int i = 0; i < k; i++) begin
			for (int j = 0; j + 1 < k; j++) window[i][j] = window[i][j+1];
			window[i][k-1] = column[i];
		end

		last_col = (c + 1 >= w);
		last_row = (r + 1 >= h);
		full = (c >= k - 1) && (r >= k - 1);

		if (full) begin
			acc = 0;
			half = k / 2;
			for (int i = 0; i < k; i++) begin
				for (int j = 0; j < k; j++) begin
					cf = kernel_rows[i][CW*j +: CW];
					acc += longint'(cf) * longint'({1'b0, window[i][j]});
				end
			end
			if (acc < 0) res.value = '0;
			else if ((acc >> FRAC) > 255) res.value = '1;
			else res.value = PIX_W'(acc >> FRAC);
			res.cx = COORD_W'(c - half);
			res.cy = COORD_W'(r - half);
			res.done = last_col && last_row;
		end

		if (last_col) begin
			col_count = 0;
			row_count = last_row ? 0 : r + 1;
		end else begin
			col_count = c + 1;
		end
		return full;
	endfunction

	// ------------------------------------------------------------------
	// Checking.
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task automatic check_filtered_pixel();
		filtered_pixel_t want;
		if (expected_pixels.size() == 0) begin
			report_mismatch($sformatf("unexpected request tdata %h tlast %b",
				m_axis_tdata, m_axis_tlast));
			return;
		end
		want = expected_pixels.pop_front();
		compare_field("filtered_value", m_axis_tdata[PIX_W-1:0], want.value);
		compare_field("centre_x", m_axis_tdata[PIX_W +: COORD_W], want.cx);
		compare_field("centre_y", m_axis_tdata[PIX_W+COORD_W +: COORD_W], want.cy);
		compare_field("tdata padding", m_axis_tdata[OUT_TDATA_W-1:PIX_W+2*COORD_W], '0);
		compare_field("frame_done", m_axis_tlast, want.done);
	endtask

	// Output side: check whatever handshakes at this edge, then decide the
	// next ready. A running hold-off forces ready low regardless of mode.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) check_filtered_pixel();
		m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
	end

	// ------------------------------------------------------------------
	// Shared drivers. Every task starts and ends just after a rising edge.
	// ------------------------------------------------------------------
	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_SENDER_LIGHT: begin
				send_idle_pct = 12;
				recv_idle_pct = 85;
			end
			IDLE_RECEIVER_LIGHT: begin
				send_idle_pct = 85;
				recv_idle_pct = 12;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	// Offers one pixel request and waits for the handshake. Valid stays high
	// afterwards so that back-to-back pixels go out without a bubble.
	task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic sof);
		filtered_pixel_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pix;
		s_axis_tuser <= sof;
		do @(posedge clk); while (!s_axis_tready);
		if (convolve_pixel(pix, sof, res)) expected_pixels.push_back(res);
	endtask

	// Stops the pixel stream and waits until every predicted pixel has come
	// back, plus the pipeline depth for pixels that produce nothing.
	task automatic settle_block();
		int guard;
		guard = 0;
		s_axis_tvalid <= 1'b0;
		while (expected_pixels.size() > 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		if (expected_pixels.size() > 0) begin
			report_mismatch($sformatf("%0d predicted pixels never arrived",
				expected_pixels.size()));
			expected_pixels.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write; the shadow follows at once since nothing is in flight.
	task automatic write_reg(input kc2d_reg_t idx, input logic [KROW_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_KERNEL_SIZE:  ksize_reg = v[KSIZE_W-1:0];
			REG_FRAME_WIDTH:  width_reg = v[DIM_W-1:0];
			REG_FRAME_HEIGHT: height_reg = v[DIM_W-1:0];
			default:          kernel_rows[int'(idx)] = v;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [KROW_W-1:0] make_kernel_row(input kernel_kind_t kind);
		logic [KROW_W-1:0] row;
		logic [CW-1:0] cf;
		for (int j = 0; j < KROW_W / CW; j++) begin
			case (kind)
				KERNEL_SMOOTH:   cf = CW'($urandom_range(0, 256));
				KERNEL_SIGNED:   cf = CW'($urandom_range(0, 1024)) - CW'(512);
				KERNEL_WILD:     cf = CW'($urandom);
				KERNEL_ZERO:     cf = '0;
				KERNEL_ALL_ONES: cf = '1;
				KERNEL_MAX_POS:  cf = {1'b0, {(CW-1){1'b1}}};
				default:         cf = {1'b1, {(CW-1){1'b0}}};
			endcase
			row[CW*j +: CW] = cf;
		end
		return row;
	endfunction

	task automatic load_kernel(input kernel_kind_t kind);
		for (int r = 0; r < NUM_KROWS; r++)
			write_reg(kc2d_reg_t'(r), make_kernel_row(kind));
	endtask

	// Mostly in-range kernels so the sums stay interesting; the rest push
	// the accumulator to its saturating and negative ends.
	function automatic kernel_kind_t pick_kernel_kind();
		case ($urandom_range(0, 15))
			0:       return KERNEL_ZERO;
			1:       return KERNEL_ALL_ONES;
			2:       return KERNEL_MAX_POS;
			3:       return KERNEL_MAX_NEG;
			4, 5, 6: return KERNEL_WILD;
			7, 8, 9, 10, 11: return KERNEL_SMOOTH;
			default: return KERNEL_SIGNED;
		endcase
	endfunction

	// Frame sides are kept small so that windows fill quickly; zero, one,
	// the exact maximum and an oversized value show up now and then.
	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(0, 11))
			0:       return '0;
			1:       return '1;
			2:       return DIM_W'(MAX_W);
			3:       return DIM_W'(1);
			4:       return DIM_W'(2);
			default: return DIM_W'($urandom_range(3, 12));
		endcase
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// The reset kernel on a 5x5 frame: black, white and alternating bit
	// patterns, so the window centre and the frame_done flag can be seen.
	// The width write carries junk above the register's width.
	task automatic test_reset_kernel();
		logic [PIX_W-1:0] pattern[25] = '{
			8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
			8'hAA, 8'h55, 8'h01, 8'h80, 8'h7F,
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h55, 8'hAA, 8'hFE, 8'h02, 8'hFF
		};
		write_reg(REG_FRAME_WIDTH, {{(KROW_W-DIM_W){1'b1}}, DIM_W'(5)});
		write_reg(REG_FRAME_HEIGHT, DIM_W'(5));
		for (int i = 0; i < 25; i++) push_pixel(pattern[i], i == 0);
		settle_block();
	endtask

	// Every kernel_size code, including zero, the even ones and those past
	// the largest supported side, on a frame just big enough for 5x5.
	task automatic test_kernel_sizes();
		for (int sz = 0; sz < 8; sz++) begin
			load_kernel(sz[0] ? KERNEL_SMOOTH : KERNEL_SIGNED);
			write_reg(REG_KERNEL_SIZE, {{(KROW_W-KSIZE_W){1'b1}}, KSIZE_W'(sz)});
			write_reg(REG_FRAME_WIDTH, DIM_W'(6));
			write_reg(REG_FRAME_HEIGHT, DIM_W'(5));
			for (int i = 0; i < 30; i++) push_pixel(pick_pixel(), i == 0);
			settle_block();
		end
	endtask

	// Random settings, each followed by a few frames. Most frames start with
	// a start-of-frame pixel and run their full length; some are cut short,
	// some carry a stray start-of-frame, and some settings continue from the
	// old position so the counters must wrap against the new size.
	task automatic test_random_frames(input int budget);
		int sent, len, wd, ht;
		bit fresh;
		sent = 0;
		while (sent < budget) begin
			load_kernel(pick_kernel_kind());
			write_reg(REG_KERNEL_SIZE, KSIZE_W'($urandom_range(0, 7)));
			write_reg(REG_FRAME_WIDTH, pick_dim());
			write_reg(REG_FRAME_HEIGHT, pick_dim());
			wd = clamp_dim(width_reg, MAX_W);
			ht = clamp_dim(height_reg, MAX_HEIGHT);
			fresh = ($urandom_range(0, 4) != 0);
			repeat ($urandom_range(1, 3)) begin
				len = wd * ht;
				if (len > 160) len = $urandom_range(30, 160);
				else if ($urandom_range(0, 7) == 0) len = $urandom_range(1, len);
				for (int i = 0; i < len; i++)
					push_pixel(pick_pixel(), (i == 0 && fresh) || $urandom_range(0, 59) == 0);
				sent += len;
				fresh = 1'b1;
			end
			settle_block();
		end
	endtask

	// Identity 1x1 kernel so every pixel yields a request. The output side
	// holds off for a long stretch while pixels keep coming, which must fill
	// the block and stall its input. Afterwards the sender pauses until all
	// results are back, then carries on in the same frame.
	task automatic test_backpressure();
		int saved_pct;
		saved_pct = send_idle_pct;
		send_idle_pct = 0;
		write_reg(REG_KERNEL_ROW_0, KROW_W'(1 << FRAC));
		write_reg(REG_KERNEL_SIZE, KSIZE_W'(1));
		write_reg(REG_FRAME_WIDTH, DIM_W'(16));
		write_reg(REG_FRAME_HEIGHT, DIM_W'(16));
		fork
			begin
				@(posedge clk);
				rx_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		for (int i = 0; i < 96; i++) push_pixel(pick_pixel(), i == 0);
		settle_block();
		send_idle_pct = saved_pct;
		for (int i = 0; i < 32; i++) push_pixel(pick_pixel(), 1'b0);
		settle_block();
	endtask

	// ------------------------------------------------------------------
	// Sequence. The block clears its line memory after reset with its input
	// not ready; the pixel driver simply waits that out.
	// ------------------------------------------------------------------
	initial begin
		reset_predictor();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		set_idling(IDLE_SENDER_LIGHT);
		test_reset_kernel();
		test_kernel_sizes();
		test_random_frames(90);

		set_idling(IDLE_RECEIVER_LIGHT);
		test_random_frames(90);
		test_backpressure();

		set_idling(IDLE_NONE);
		test_random_frames(90);

		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
